### src/ipem_pkg.sv
// Package with the beat types, controller command and status types and constants.
`default_nettype none
package ipem_pkg;

   localparam int KEY_W   = 32;
   localparam int PORT_W  = 8;
   localparam int ENTRY_W = 1 + KEY_W + PORT_W;

   // Number of cycles the registered bucket hash takes after a request is captured.
   localparam int HASH_STEPS = 5;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_ADD    = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [KEY_W-1:0]  ip_address;
      logic [PORT_W-1:0] port_in;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [PORT_W-1:0] port_out;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [PORT_W-1:0] port;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic clear_step;
      logic rd_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage
`default_nettype wire

### src/ip_exact_match_hash_table.sv
// Top level of the IPv4 exact-match hash table.
// A request beat is accepted in the idle state, then passes the five-stage octet-product and
// modulo hash, one bucket-row read and a compare-and-write step on the memory port; rsp_valid
// rises after the commit, later if the result slot is still occupied.
// A new beat is accepted only after the previous one has been committed.
// Reset: synchronous; afterwards a clearing pass writes every bucket row, with req_ready low
// until it finishes.
`default_nettype none
module ip_exact_match_hash_table #(
   parameter int BUCKETS = 1024,
   parameter int WAYS    = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ipem_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output ipem_pkg::rsp_type       rsp_data
);
   import ipem_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ipem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ipem_dp #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

### src/ipem_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module ipem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic                                  re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                      wdata,
   output logic      [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### src/ipem_ctrl.sv
// Controller state machine: clearing pass, hash wait, bucket read and commit.
`default_nettype none
module ipem_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ipem_pkg::cmd_type      cmd,
   input  wire ipem_pkg::stat_type stat
);
   import ipem_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;

   localparam int STEP_W = $clog2(HASH_STEPS + 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               step_in      = '0;
               state_in     = ST_CALC;
            end
         end
         ST_CALC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(HASH_STEPS - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### src/ipem_dp.sv
// Datapath: octet-product hash, bucket memory, way compare and result register.
`default_nettype none
module ipem_dp #(
   parameter int BUCKETS = 1024,
   parameter int WAYS    = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ipem_pkg::req_type  req_data,
   input  wire ipem_pkg::cmd_type  cmd,
   output ipem_pkg::stat_type      stat,
   output ipem_pkg::rsp_type       rsp_data
);
   import ipem_pkg::*;

   localparam int ADDR_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W  = WAYS * ENTRY_W;
   localparam logic [31:0] B32   = 32'(BUCKETS);
   localparam logic [31:0] RECIP = (BUCKETS == 1) ? 32'hFFFF_FFFF
                                                  : 32'((64'd1 << 32) / BUCKETS);

   req_type           req_ff;
   logic [15:0]       p12_ff, p34_ff;
   logic [31:0]       prod_ff, prod1_ff, prod2_ff;
   logic [31:0]       qm_ff, qb_ff;
   logic [ADDR_W-1:0] bucket_ff, bucket_in;
   logic [ADDR_W-1:0] clr_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [63:0]       qm_full, qb_full;
   logic [31:0]       diff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [ROW_W-1:0]  ram_wdata, rd_row, new_row;

   logic              match_any, free_any;
   logic [WAY_W-1:0]  msel, fsel;
   entry_type         ent;

   // The quotient estimate is low by at most one, so a single subtract finishes the remainder.
   assign qm_full = 64'(prod_ff) * 64'(RECIP);
   assign qb_full = 64'(qm_ff) * 64'(B32);
   assign diff    = prod2_ff - qb_ff;

   always_comb begin
      if (diff >= B32) begin
         bucket_in = ADDR_W'(diff - B32);
      end else begin
         bucket_in = ADDR_W'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      p12_ff    <= 16'(req_ff.ip_address[31:24]) * 16'(req_ff.ip_address[23:16]);
      p34_ff    <= 16'(req_ff.ip_address[15:8]) * 16'(req_ff.ip_address[7:0]);
      prod_ff   <= 32'(p12_ff) * 32'(p34_ff);
      qm_ff     <= qm_full[63:32];
      prod1_ff  <= prod_ff;
      qb_ff     <= qb_full[31:0];
      prod2_ff  <= prod1_ff;
      bucket_ff <= bucket_in;
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clr_ff == ADDR_W'(BUCKETS - 1));

   always_comb begin
      match_any = 1'b0;
      free_any  = 1'b0;
      msel      = '0;
      fsel      = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         ent = entry_type'(rd_row[w*ENTRY_W +: ENTRY_W]);
         if (ent.valid && (ent.key == req_ff.ip_address)) begin
            match_any = 1'b1;
            msel      = WAY_W'(w);
         end
         if (!ent.valid) begin
            free_any = 1'b1;
            fsel     = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_row = rd_row;
      for (int w = 0; w < WAYS; w++) begin
         if (req_ff.opcode == OP_ADD) begin
            if (match_any && (msel == WAY_W'(w))) begin
               new_row[w*ENTRY_W +: PORT_W] = req_ff.port_in;
            end else if (!match_any && free_any && (fsel == WAY_W'(w))) begin
               new_row[w*ENTRY_W +: ENTRY_W] = {1'b1, req_ff.ip_address, req_ff.port_in};
            end
         end
      end
   end

   always_comb begin
      rsp_in.hit = match_any;
      if (req_ff.opcode == OP_LOOKUP) begin
         rsp_in.status   = STATUS_DONE;
         rsp_in.port_out = '0;
         for (int w = 0; w < WAYS; w++) begin
            if (match_any && (msel == WAY_W'(w))) begin
               rsp_in.port_out = rd_row[w*ENTRY_W +: PORT_W];
            end
         end
      end else begin
         rsp_in.port_out = '0;
         rsp_in.status   = (!match_any && !free_any) ? STATUS_FULL : STATUS_DONE;
      end
   end

   assign ram_we    = cmd.clear_step || cmd.commit;
   assign ram_addr  = cmd.clear_step ? clr_ff : bucket_ff;
   assign ram_wdata = cmd.clear_step ? '0 : new_row;

   ipem_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (cmd.rd_en),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (rd_row)
   );

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire
